// ===== sv/mtg_pkg.sv =====
// ----------------------------------------------------------------------------
// mtg_pkg
// Types, codes and constants shared by the MT19937 generator modules.
// ----------------------------------------------------------------------------
package mtg_pkg;

	localparam int STATE_WORDS  = 624;
	localparam int SHIFT_OFFSET = 397;
	localparam int ADDR_W       = $clog2(STATE_WORDS);
	localparam int WORD_W       = 32;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [WORD_W-1:0] word_t;

	localparam addr_t LAST_ADDR = addr_t'(STATE_WORDS - 1);
	localparam addr_t FAR_WRAP  = addr_t'(STATE_WORDS - SHIFT_OFFSET);
	localparam addr_t FAR_STEP  = addr_t'(SHIFT_OFFSET);

	localparam word_t TWIST_CONST  = 32'h9908_b0df;
	localparam word_t UPPER_MASK   = 32'h8000_0000;
	localparam word_t LOWER_MASK   = 32'h7fff_ffff;
	localparam word_t INIT_MUL     = 32'd1812433253;
	localparam word_t DEFAULT_SEED = 32'd5489;
	localparam word_t TEMPER_B     = 32'h9d2c_5680;
	localparam word_t TEMPER_C     = 32'hefc6_0000;

	// action codes of the input item
	localparam logic ACT_SEED = 1'b0;
	localparam logic ACT_DRAW = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_RD_CUR,
		ST_RD_NXT,
		ST_RD_FAR,
		ST_TWIST,
		ST_RESULT
	} state_t;

	typedef enum logic [1:0] {
		SEL_CUR,
		SEL_NXT,
		SEL_FAR
	} rd_sel_t;

	typedef struct packed {
		logic    load_seed;
		logic    use_default;
		logic    seed_step;
		rd_sel_t rd_sel;
		logic    cap_cur;
		logic    cap_nxt;
		logic    twist;
		logic    out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic seed_last;
	} ctrl_stat_t;

endpackage

// ===== sv/mtg_ram.sv =====
// ----------------------------------------------------------------------------
// mtg_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mtg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== sv/mtg_ctrl.sv =====
// ----------------------------------------------------------------------------
// mtg_ctrl
// Sequencer for seeding and per-draw twisting, plus handshake control.
// ----------------------------------------------------------------------------
module mtg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                action,
	output logic                out_valid,
	input  logic                out_ready,
	output mtg_pkg::ctrl_cmd_t  cmd,
	input  mtg_pkg::ctrl_stat_t stat
);

	mtg_pkg::state_t state_q, state_d;
	logic            seeded_q, seeded_d;
	logic            pend_q, pend_d;
	logic            out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mtg_pkg::ST_IDLE;
			seeded_q    <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			seeded_q    <= seeded_d;
			pend_q      <= pend_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		seeded_d    = seeded_q;
		pend_d      = pend_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.rd_sel  = mtg_pkg::SEL_CUR;
		out_valid_d = out_valid_q;
		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			mtg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (action == mtg_pkg::ACT_SEED) begin
						cmd.load_seed = 1'b1;
						seeded_d      = 1'b1;
						pend_d        = 1'b0;
						state_d       = mtg_pkg::ST_SEED;
					end else if (!seeded_q) begin
						// draw before any seed: seed with the default, then draw
						cmd.load_seed   = 1'b1;
						cmd.use_default = 1'b1;
						seeded_d        = 1'b1;
						pend_d          = 1'b1;
						state_d         = mtg_pkg::ST_SEED;
					end else begin
						state_d = mtg_pkg::ST_RD_CUR;
					end
				end
			end
			mtg_pkg::ST_SEED: begin
				cmd.seed_step = 1'b1;
				if (stat.seed_last) begin
					pend_d  = 1'b0;
					state_d = pend_q ? mtg_pkg::ST_RD_CUR : mtg_pkg::ST_IDLE;
				end
			end
			mtg_pkg::ST_RD_CUR: begin
				cmd.rd_sel = mtg_pkg::SEL_CUR;
				state_d    = mtg_pkg::ST_RD_NXT;
			end
			mtg_pkg::ST_RD_NXT: begin
				cmd.rd_sel  = mtg_pkg::SEL_NXT;
				cmd.cap_cur = 1'b1;
				state_d     = mtg_pkg::ST_RD_FAR;
			end
			mtg_pkg::ST_RD_FAR: begin
				cmd.rd_sel  = mtg_pkg::SEL_FAR;
				cmd.cap_nxt = 1'b1;
				state_d     = mtg_pkg::ST_TWIST;
			end
			mtg_pkg::ST_TWIST: begin
				cmd.twist = 1'b1;
				state_d   = mtg_pkg::ST_RESULT;
			end
			mtg_pkg::ST_RESULT: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = mtg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mtg_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/mtg_datapath.sv =====
// ----------------------------------------------------------------------------
// mtg_datapath
// Word store, seed recurrence, single-word twist and tempering.
// ----------------------------------------------------------------------------
module mtg_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         seed_value,
	input  mtg_pkg::ctrl_cmd_t  cmd,
	output mtg_pkg::ctrl_stat_t stat,
	output logic [31:0]         random_word
);

	mtg_pkg::addr_t pos_q, idx_q;
	mtg_pkg::word_t seed_w_q, cur_q, nxt_q, new_q, random_word_q;

	mtg_pkg::addr_t idx_inc, pos_nxt, pos_far, rd_addr, wr_addr;
	mtg_pkg::word_t rd_data, wr_data, seed_mix, seed_next, mix, twisted;
	logic           wr_en;

	function automatic mtg_pkg::word_t temper(input mtg_pkg::word_t w);
		mtg_pkg::word_t y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & mtg_pkg::TEMPER_B);
		y = y ^ ((y << 15) & mtg_pkg::TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	assign idx_inc   = idx_q + mtg_pkg::addr_t'(1);
	assign seed_mix  = seed_w_q ^ (seed_w_q >> 30);
	assign seed_next = mtg_pkg::word_t'(mtg_pkg::INIT_MUL * seed_mix)
		+ mtg_pkg::word_t'(idx_inc);

	assign stat.seed_last = (idx_q == mtg_pkg::LAST_ADDR);

	assign pos_nxt = (pos_q == mtg_pkg::LAST_ADDR) ? '0 : pos_q + mtg_pkg::addr_t'(1);
	assign pos_far = (pos_q >= mtg_pkg::FAR_WRAP) ? pos_q - mtg_pkg::FAR_WRAP
		: pos_q + mtg_pkg::FAR_STEP;

	always_comb begin
		case (cmd.rd_sel)
			mtg_pkg::SEL_CUR: rd_addr = pos_q;
			mtg_pkg::SEL_NXT: rd_addr = pos_nxt;
			mtg_pkg::SEL_FAR: rd_addr = pos_far;
			default:          rd_addr = pos_q;
		endcase
	end

	// rd_data holds the far word during the twist cycle
	assign mix     = (cur_q & mtg_pkg::UPPER_MASK) | (nxt_q & mtg_pkg::LOWER_MASK);
	assign twisted = rd_data ^ (mix >> 1) ^ (mix[0] ? mtg_pkg::TWIST_CONST : '0);

	assign wr_en   = cmd.seed_step || cmd.twist;
	assign wr_addr = cmd.seed_step ? idx_q : pos_q;
	assign wr_data = cmd.seed_step ? seed_w_q : twisted;

	mtg_ram #(
		.WIDTH(mtg_pkg::WORD_W),
		.DEPTH(mtg_pkg::STATE_WORDS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.load_seed) begin
				pos_q <= '0;
				idx_q <= '0;
			end else if (cmd.seed_step) begin
				idx_q <= idx_inc;
			end else if (cmd.out_load) begin
				pos_q <= pos_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_seed) begin
			seed_w_q <= cmd.use_default ? mtg_pkg::DEFAULT_SEED : seed_value;
		end else if (cmd.seed_step) begin
			seed_w_q <= seed_next;
		end
		if (cmd.cap_cur) begin
			cur_q <= rd_data;
		end
		if (cmd.cap_nxt) begin
			nxt_q <= rd_data;
		end
		if (cmd.twist) begin
			new_q <= twisted;
		end
		if (cmd.out_load) begin
			random_word_q <= temper(new_q);
		end
	end

	assign random_word = random_word_q;

endmodule

// ===== sv/mersenne_twister_generator_top.sv =====
// ----------------------------------------------------------------------------
// mersenne_twister_generator_top
// MT19937 generator: seed fills a 624-word store, each draw twists and
// tempers one word.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-------------------------
//  input   | in_valid / in_ready | action, seed_value
//  output  | out_valid/out_ready | random_word
//
//  Seed: each transfer writes all 624 store words, one per SEED step.
//  Draw: each transfer steps through RD_CUR, RD_NXT, RD_FAR, TWIST and
//  RESULT; the store RAM's single read port takes three reads.
//  A draw before any seed first runs the seed with the default value.
//  No clearing pass after reset; the store is written before any read.
//  A result waiting on out_ready stalls only the next draw's RESULT state.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [31:0] seed_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] random_word
);

	mtg_pkg::ctrl_cmd_t  cmd;
	mtg_pkg::ctrl_stat_t stat;

	mtg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	mtg_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.seed_value  (seed_value),
		.cmd         (cmd),
		.stat        (stat),
		.random_word (random_word)
	);

`ifndef NO_ASSERTIONS
	// never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid && !out_ready))
		else $error("result overwritten while waiting");

	// a seed starts only on an input transfer
	a_seed_on_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_seed |-> (in_valid && in_ready))
		else $error("seed started without transfer");

	// seeding stops after the last store word
	a_seed_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.seed_step && stat.seed_last) |=> !cmd.seed_step)
		else $error("seeding ran past the store");

	// a twisted word is always loaded into the output register before new input is taken
	a_twist_then_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.twist |=> !in_ready)
		else $error("input taken before result loaded");
`endif

endmodule

// ===== verif/tb_mersenne_twister_generator_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mersenne_twister_generator_top
// Drives seed and draw transfers into the MT19937 generator with random gaps
// on both channels and one long output stall. Each random_word is compared
// against a word-accurate predictor kept inside a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_mersenne_twister_generator_top;

	localparam int RANDOM_ITEMS   = 2000;
	localparam int IDLE_PCT       = 18;
	localparam int HOLD_AFTER     = 700;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 4000;

	class mt_word_predictor;
		mtg_pkg::word_t store_words[mtg_pkg::STATE_WORDS];
		int unsigned    rd_pos;
		bit             seeded;
		mtg_pkg::word_t pending_words[$];
		int unsigned    error_count;

		function new();
			rd_pos      = mtg_pkg::STATE_WORDS;
			seeded      = 1'b0;
			error_count = 0;
		endfunction

		function void fill_store(mtg_pkg::word_t seed);
			mtg_pkg::word_t prev;
			store_words[0] = seed;
			for (int i = 1; i < mtg_pkg::STATE_WORDS; i++) begin
				prev = store_words[i-1];
				store_words[i] = mtg_pkg::INIT_MUL * (prev ^ (prev >> 30))
					+ mtg_pkg::word_t'(i);
			end
			rd_pos = mtg_pkg::STATE_WORDS;
			seeded = 1'b1;
		endfunction

		// regenerate the whole set in place, in index order
		function void twist_store();
			int             nxt;
			int             far;
			mtg_pkg::word_t mix;
			for (int i = 0; i < mtg_pkg::STATE_WORDS; i++) begin
				nxt = (i + 1 < mtg_pkg::STATE_WORDS) ? i + 1 : 0;
				far = i + mtg_pkg::SHIFT_OFFSET;
				if (far >= mtg_pkg::STATE_WORDS)
					far -= mtg_pkg::STATE_WORDS;
				mix = (store_words[i] & mtg_pkg::UPPER_MASK)
					| (store_words[nxt] & mtg_pkg::LOWER_MASK);
				store_words[i] = store_words[far] ^ (mix >> 1)
					^ (mix[0] ? mtg_pkg::TWIST_CONST : '0);
			end
			rd_pos = 0;
		endfunction

		function mtg_pkg::word_t temper(mtg_pkg::word_t raw);
			mtg_pkg::word_t y;
			y = raw;
			y ^= y >> 11;
			y ^= (y << 7) & mtg_pkg::TEMPER_B;
			y ^= (y << 15) & mtg_pkg::TEMPER_C;
			y ^= y >> 18;
			return y;
		endfunction

		function void note_transfer(logic act, mtg_pkg::word_t seed);
			if (act == mtg_pkg::ACT_SEED) begin
				fill_store(seed);
				return;
			end
			if (!seeded)
				fill_store(mtg_pkg::DEFAULT_SEED);
			if (rd_pos >= mtg_pkg::STATE_WORDS)
				twist_store();
			pending_words.push_back(temper(store_words[rd_pos]));
			rd_pos++;
		endfunction

		function void check_word(mtg_pkg::word_t actual);
			mtg_pkg::word_t exp_word;
			if (pending_words.size() == 0) begin
				$display("%0t: random_word %h with no draw outstanding", $time, actual);
				error_count++;
				return;
			end
			exp_word = pending_words.pop_front();
			if (exp_word !== actual) begin
				$display("%0t: random_word expected %h actual %h", $time, exp_word, actual);
				error_count++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        action;
	logic [31:0] seed_value;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] random_word;

	mt_word_predictor word_pred = new();

	bit steady_run;
	int words_seen;
	int quiet_cycles;

	mersenne_twister_generator_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.seed_value (seed_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.random_word(random_word)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// offer one item; returns at the edge where it transfers
	task automatic offer_item(input logic act, input mtg_pkg::word_t seed);
		@(negedge clk);
		while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		action     <= act;
		seed_value <= seed;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic seed_then_draw(input mtg_pkg::word_t seed, input int draws);
		offer_item(mtg_pkg::ACT_SEED, seed);
		for (int k = 0; k < draws; k++)
			offer_item(mtg_pkg::ACT_DRAW, $urandom);
	endtask

	always @(posedge clk) begin
		if (in_valid && in_ready)
			word_pred.note_transfer(action, seed_value);
		if (out_valid && out_ready) begin
			word_pred.check_word(random_word);
			words_seen++;
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: random back-pressure plus one long hold-off
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && words_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
			end else begin
				out_ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		int draws_since;
		int run_target;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		action       = mtg_pkg::ACT_SEED;
		seed_value   = '0;
		out_ready    = 1'b0;
		steady_run   = 1'b0;
		words_seen   = 0;
		quiet_cycles = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// draws before any seed fall back to the default seed
		for (int k = 0; k < 3; k++)
			offer_item(mtg_pkg::ACT_DRAW, $urandom);
		seed_then_draw('0, 3);
		seed_then_draw('1, 2);
		// back-to-back seeds: the last one wins
		offer_item(mtg_pkg::ACT_SEED, $urandom);
		seed_then_draw(32'h1234_5678, 2);
		seed_then_draw(mtg_pkg::DEFAULT_SEED, 2);
		seed_then_draw(32'h8000_0000, 1);
		seed_then_draw(32'h0000_0001, 1);

		// long draw runs cross the set boundary; reseed now and then
		draws_since = 0;
		run_target  = $urandom_range(1400, 20);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady_run = (n >= 1200 && n < 1500);
			if (draws_since >= run_target) begin
				case ($urandom_range(3))
					0:       offer_item(mtg_pkg::ACT_SEED, '0);
					1:       offer_item(mtg_pkg::ACT_SEED, '1);
					default: offer_item(mtg_pkg::ACT_SEED, $urandom);
				endcase
				draws_since = 0;
				run_target  = $urandom_range(1400, 20);
			end else begin
				offer_item(mtg_pkg::ACT_DRAW, $urandom);
				draws_since++;
			end
		end
		steady_run = 1'b0;
		@(negedge clk);
		in_valid <= 1'b0;

		while (word_pred.pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (word_pred.error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
